// ===== hw/rtl/vpy_pkg.sv =====
// Package for the vector to pitch/yaw core: shared constants, the status flag
// struct and the CORDIC arctangent table.
// No dependencies; every other file in hw/rtl uses it.
package vpy_pkg;

    // Default configuration of the core.
    localparam int COORD_WIDTH_DEF  = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    // Fixed-point layout.
    localparam int GUARD_BITS = 12;
    localparam int TABLE_LEN  = 24;
    localparam int ACC_W      = 26;
    localparam int ROUND_SH   = 9;
    localparam int GAIN_Q16   = 107922;
    localparam int DEG90_Q16  = 90 * 65536;

    // Output range limits in units of 1/128 degree.
    localparam int YAW_MAX   = 23040;
    localparam int PITCH_MAX = 11520;

    // Component tests taken at the front and carried down the pipe.
    typedef struct packed {
        logic xy_zero;
        logic x_zero;
        logic y_zero;
        logic x_pos;
        logic y_pos;
        logic z_zero;
        logic z_pos;
    } t_flags;

    // atan(2^-i) in degrees with 16 fractional bits, rounded to nearest.
    function automatic logic signed [ACC_W-1:0] atan_entry(input int idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            0:       v = ACC_W'(2949120);
            1:       v = ACC_W'(1740967);
            2:       v = ACC_W'(919879);
            3:       v = ACC_W'(466945);
            4:       v = ACC_W'(234379);
            5:       v = ACC_W'(117304);
            6:       v = ACC_W'(58666);
            7:       v = ACC_W'(29335);
            8:       v = ACC_W'(14668);
            9:       v = ACC_W'(7334);
            10:      v = ACC_W'(3667);
            11:      v = ACC_W'(1833);
            12:      v = ACC_W'(917);
            13:      v = ACC_W'(458);
            14:      v = ACC_W'(229);
            15:      v = ACC_W'(115);
            16:      v = ACC_W'(57);
            17:      v = ACC_W'(29);
            18:      v = ACC_W'(14);
            19:      v = ACC_W'(7);
            20:      v = ACC_W'(4);
            21:      v = ACC_W'(2);
            22:      v = ACC_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/vpy_front.sv =====
// Front stage: quarter-turn pre-rotation into the right half plane, the
// scaled z product for the pitch pass and the component tests.
// Depends on vpy_pkg.
module vpy_front #(
    parameter int COORD_WIDTH = vpy_pkg::COORD_WIDTH_DEF,
    parameter int DATA_W      = vpy_pkg::COORD_WIDTH_DEF + vpy_pkg::GUARD_BITS + 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [COORD_WIDTH-1:0]       i_vec_x,
    input  logic signed [COORD_WIDTH-1:0]       i_vec_y,
    input  logic signed [COORD_WIDTH-1:0]       i_vec_z,
    output logic                                o_valid,
    output vpy_pkg::t_flags                     o_flags,
    output logic signed [DATA_W-1:0]            o_x,
    output logic signed [DATA_W-1:0]            o_y,
    output logic signed [vpy_pkg::ACC_W-1:0]    o_acc,
    output logic signed [DATA_W-1:0]            o_aux
);

    localparam int GW   = COORD_WIDTH + vpy_pkg::GUARD_BITS;
    localparam int PW   = COORD_WIDTH + 18;
    localparam int SH_Z = vpy_pkg::GUARD_BITS + 16 - vpy_pkg::GUARD_BITS - 12;
    localparam logic signed [17:0] NEG_GAIN = -18'(vpy_pkg::GAIN_Q16);
    localparam logic signed [vpy_pkg::ACC_W-1:0] ACC_90 = vpy_pkg::ACC_W'(vpy_pkg::DEG90_Q16);

    logic signed [DATA_W-1:0]         w_xg;
    logic signed [DATA_W-1:0]         w_yg;
    logic signed [PW-1:0]             w_prod;
    logic                             r_valid;
    vpy_pkg::t_flags                  r_flags;
    vpy_pkg::t_flags                  n_flags;
    logic signed [DATA_W-1:0]         r_x;
    logic signed [DATA_W-1:0]         r_y;
    logic signed [DATA_W-1:0]         n_x;
    logic signed [DATA_W-1:0]         n_y;
    logic signed [vpy_pkg::ACC_W-1:0] r_acc;
    logic signed [vpy_pkg::ACC_W-1:0] n_acc;
    logic signed [DATA_W-1:0]         r_aux;
    logic signed [DATA_W-1:0]         n_aux;

    // Components with guard bits appended, sign-extended to the datapath.
    assign w_xg = DATA_W'($signed({i_vec_x, {vpy_pkg::GUARD_BITS{1'b0}}}));
    assign w_yg = DATA_W'($signed({i_vec_y, {vpy_pkg::GUARD_BITS{1'b0}}}));

    // Pitch start value -z*K, floored by the combined shift of 4 bits.
    assign w_prod = PW'(i_vec_z) * PW'(NEG_GAIN);
    assign n_aux  = DATA_W'($signed(w_prod[PW-1:SH_Z]));

    // Pre-rotation by a quarter turn when x is negative.
    always_comb begin
        n_x   = w_xg;
        n_y   = w_yg;
        n_acc = '0;
        if (i_vec_x < 0) begin
            if (i_vec_y >= 0) begin
                n_x   = w_yg;
                n_y   = -w_xg;
                n_acc = ACC_90;
            end else begin
                n_x   = -w_yg;
                n_y   = w_xg;
                n_acc = -ACC_90;
            end
        end
    end

    // Tests for the axis and zero special cases.
    always_comb begin
        n_flags.x_zero  = (i_vec_x == '0);
        n_flags.y_zero  = (i_vec_y == '0);
        n_flags.xy_zero = (i_vec_x == '0) && (i_vec_y == '0);
        n_flags.x_pos   = (i_vec_x > 0);
        n_flags.y_pos   = (i_vec_y > 0);
        n_flags.z_zero  = (i_vec_z == '0);
        n_flags.z_pos   = (i_vec_z > 0);
    end

    // Stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flags <= n_flags;
            r_x     <= n_x;
            r_y     <= n_y;
            r_acc   <= n_acc;
            r_aux   <= n_aux;
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_acc   = r_acc;
    assign o_aux   = r_aux;

    // GW names the guarded component width; the datapath must hold it plus growth.
    if (DATA_W < GW + 3) begin : g_width_error
        $error("vpy_front: datapath too narrow");
    end

endmodule

// ===== hw/rtl/vpy_cell.sv =====
// One CORDIC vectoring cell: a single micro-rotation by atan(2^-STEP),
// registered, with flags and an auxiliary word carried alongside.
// Depends on vpy_pkg.
module vpy_cell #(
    parameter int DATA_W = vpy_pkg::COORD_WIDTH_DEF + vpy_pkg::GUARD_BITS + 3,
    parameter int STEP   = 0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  vpy_pkg::t_flags                     i_flags,
    input  logic signed [DATA_W-1:0]            i_x,
    input  logic signed [DATA_W-1:0]            i_y,
    input  logic signed [vpy_pkg::ACC_W-1:0]    i_acc,
    input  logic signed [DATA_W-1:0]            i_aux,
    output logic                                o_valid,
    output vpy_pkg::t_flags                     o_flags,
    output logic signed [DATA_W-1:0]            o_x,
    output logic signed [DATA_W-1:0]            o_y,
    output logic signed [vpy_pkg::ACC_W-1:0]    o_acc,
    output logic signed [DATA_W-1:0]            o_aux
);

    localparam logic signed [vpy_pkg::ACC_W-1:0] ANGLE = vpy_pkg::atan_entry(STEP);

    logic signed [DATA_W-1:0]         w_dx;
    logic signed [DATA_W-1:0]         w_dy;
    logic                             r_valid;
    vpy_pkg::t_flags                  r_flags;
    logic signed [DATA_W-1:0]         r_x;
    logic signed [DATA_W-1:0]         r_y;
    logic signed [DATA_W-1:0]         n_x;
    logic signed [DATA_W-1:0]         n_y;
    logic signed [vpy_pkg::ACC_W-1:0] r_acc;
    logic signed [vpy_pkg::ACC_W-1:0] n_acc;
    logic signed [DATA_W-1:0]         r_aux;

    assign w_dx = i_y >>> STEP;
    assign w_dy = i_x >>> STEP;

    // Rotate toward the x axis by the sign of y.
    always_comb begin
        if (i_y >= 0) begin
            n_x   = i_x + w_dx;
            n_y   = i_y - w_dy;
            n_acc = i_acc + ANGLE;
        end else begin
            n_x   = i_x - w_dx;
            n_y   = i_y + w_dy;
            n_acc = i_acc - ANGLE;
        end
    end

    // Stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flags <= i_flags;
            r_x     <= n_x;
            r_y     <= n_y;
            r_acc   <= n_acc;
            r_aux   <= i_aux;
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_acc   = r_acc;
    assign o_aux   = r_aux;

endmodule

// ===== hw/rtl/vpy_out.sv =====
// Output stage: rounds both angle accumulators to 1/128 degree, applies the
// axis and zero special cases and the range limits, and holds the result.
// Depends on vpy_pkg.
module vpy_out (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  vpy_pkg::t_flags                     i_flags,
    input  logic signed [vpy_pkg::ACC_W-1:0]    i_yaw_acc,
    input  logic signed [vpy_pkg::ACC_W-1:0]    i_pitch_acc,
    output logic                                o_valid,
    output logic signed [14:0]                  o_pitch_deg,
    output logic signed [15:0]                  o_yaw_deg
);

    localparam int RW = vpy_pkg::ACC_W - vpy_pkg::ROUND_SH;
    localparam logic signed [vpy_pkg::ACC_W-1:0] HALF = vpy_pkg::ACC_W'(256);
    localparam logic signed [RW-1:0] YAW_MAX   = RW'(vpy_pkg::YAW_MAX);
    localparam logic signed [RW-1:0] PITCH_MAX = RW'(vpy_pkg::PITCH_MAX);

    logic signed [vpy_pkg::ACC_W-1:0] w_yaw_sum;
    logic signed [vpy_pkg::ACC_W-1:0] w_pitch_sum;
    logic signed [RW-1:0]             w_yaw_rnd;
    logic signed [RW-1:0]             w_pitch_rnd;
    logic signed [RW-1:0]             n_yaw;
    logic signed [RW-1:0]             n_pitch;
    logic                             r_valid;
    logic signed [14:0]               r_pitch;
    logic signed [15:0]               r_yaw;

    // Round half up to 1/128 degree.
    assign w_yaw_sum   = i_yaw_acc + HALF;
    assign w_pitch_sum = i_pitch_acc + HALF;
    assign w_yaw_rnd   = w_yaw_sum[vpy_pkg::ACC_W-1:vpy_pkg::ROUND_SH];
    assign w_pitch_rnd = w_pitch_sum[vpy_pkg::ACC_W-1:vpy_pkg::ROUND_SH];

    // Yaw: exact axis values, then fold -180 and beyond onto +180.
    always_comb begin
        if (i_flags.xy_zero) begin
            n_yaw = '0;
        end else if (i_flags.y_zero) begin
            n_yaw = i_flags.x_pos ? '0 : YAW_MAX;
        end else if (i_flags.x_zero) begin
            n_yaw = i_flags.y_pos ? PITCH_MAX : -PITCH_MAX;
        end else if (w_yaw_rnd > YAW_MAX || w_yaw_rnd <= -YAW_MAX) begin
            n_yaw = YAW_MAX;
        end else begin
            n_yaw = w_yaw_rnd;
        end
    end

    // Pitch: straight up or down on the z axis, zero for a level vector.
    always_comb begin
        if (i_flags.xy_zero) begin
            if (i_flags.z_zero) begin
                n_pitch = '0;
            end else begin
                n_pitch = i_flags.z_pos ? -PITCH_MAX : PITCH_MAX;
            end
        end else if (i_flags.z_zero) begin
            n_pitch = '0;
        end else if (w_pitch_rnd > PITCH_MAX) begin
            n_pitch = PITCH_MAX;
        end else if (w_pitch_rnd < -PITCH_MAX) begin
            n_pitch = -PITCH_MAX;
        end else begin
            n_pitch = w_pitch_rnd;
        end
    end

    // Result valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pitch <= n_pitch[14:0];
            r_yaw   <= n_yaw[15:0];
        end
    end

    assign o_valid     = r_valid;
    assign o_pitch_deg = r_pitch;
    assign o_yaw_deg   = r_yaw;

endmodule

// ===== hw/rtl/vector_to_pitch_yaw_core.sv =====
// Top level of the vector to pitch/yaw core: front stage, two chains of
// CORDIC cells (yaw, then pitch) and the output stage.
// Depends on vpy_pkg, vpy_front, vpy_cell and vpy_out.
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries one direction vector per
//   transaction (i_vec_x, i_vec_y, i_vec_z, signed Q16.8). Output channel
//   o_out_valid / i_out_ready carries pitch and yaw in 1/128 degree.
//   STEPS = min(CORDIC_STEPS, 24); the pipe holds one front
//   stage, STEPS yaw cells, STEPS pitch cells and one output register.
//   Throughput is one vector per cycle while not held; every cell holds its own vector.
//   The pitch chain needs the magnitude that the last yaw cell leaves, so
//   the two chains run in series.
//   All stages advance together whenever the output register is empty or
//   being taken. While the receiver holds i_out_ready low with a result
//   waiting, the whole pipe holds and o_in_ready is low; bubbles in the
//   pipe stay where they are until the result is taken.
//   Reset (synchronous, active low) clears all valid bits; no result is
//   shown until a vector has gone through. There is no stored state.
module vector_to_pitch_yaw_core #(
    parameter int COORD_WIDTH  = vpy_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STEPS = vpy_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_WIDTH-1:0] i_vec_x,
    input  logic signed [COORD_WIDTH-1:0] i_vec_y,
    input  logic signed [COORD_WIDTH-1:0] i_vec_z,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [14:0]            o_pitch_deg,
    output logic signed [15:0]            o_yaw_deg
);

    localparam int DATA_W = COORD_WIDTH + vpy_pkg::GUARD_BITS + 3;
    localparam int STEPS  = (CORDIC_STEPS < vpy_pkg::TABLE_LEN) ?
                            CORDIC_STEPS : vpy_pkg::TABLE_LEN;

    logic w_adv;

    // Yaw chain links.
    logic                             w_yv   [0:STEPS];
    vpy_pkg::t_flags                  w_yf   [0:STEPS];
    logic signed [DATA_W-1:0]         w_yx   [0:STEPS];
    logic signed [DATA_W-1:0]         w_yy   [0:STEPS];
    logic signed [vpy_pkg::ACC_W-1:0] w_ya   [0:STEPS];
    logic signed [DATA_W-1:0]         w_yaux [0:STEPS];

    // Pitch chain links.
    logic                             w_pv   [0:STEPS];
    vpy_pkg::t_flags                  w_pf   [0:STEPS];
    logic signed [DATA_W-1:0]         w_px   [0:STEPS];
    logic signed [DATA_W-1:0]         w_py   [0:STEPS];
    logic signed [vpy_pkg::ACC_W-1:0] w_pa   [0:STEPS];
    logic signed [DATA_W-1:0]         w_paux [0:STEPS];

    // The pipe moves whenever the output register can take a new result.
    assign w_adv      = !o_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    vpy_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .DATA_W      (DATA_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (i_in_valid),
        .i_vec_x (i_vec_x),
        .i_vec_y (i_vec_y),
        .i_vec_z (i_vec_z),
        .o_valid (w_yv[0]),
        .o_flags (w_yf[0]),
        .o_x     (w_yx[0]),
        .o_y     (w_yy[0]),
        .o_acc   (w_ya[0]),
        .o_aux   (w_yaux[0])
    );

    // Yaw cells: the auxiliary word carries the pitch start value -z*K.
    for (genvar g = 0; g < STEPS; g++) begin : g_yaw
        vpy_cell #(
            .DATA_W (DATA_W),
            .STEP   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_yv[g]),
            .i_flags (w_yf[g]),
            .i_x     (w_yx[g]),
            .i_y     (w_yy[g]),
            .i_acc   (w_ya[g]),
            .i_aux   (w_yaux[g]),
            .o_valid (w_yv[g+1]),
            .o_flags (w_yf[g+1]),
            .o_x     (w_yx[g+1]),
            .o_y     (w_yy[g+1]),
            .o_acc   (w_ya[g+1]),
            .o_aux   (w_yaux[g+1])
        );
    end

    // Pitch chain starts from (K * horizontal length, -z*K); the yaw angle
    // rides along in the auxiliary word.
    assign w_pv[0]   = w_yv[STEPS];
    assign w_pf[0]   = w_yf[STEPS];
    assign w_px[0]   = w_yx[STEPS];
    assign w_py[0]   = w_yaux[STEPS];
    assign w_pa[0]   = '0;
    assign w_paux[0] = DATA_W'(w_ya[STEPS]);

    for (genvar g = 0; g < STEPS; g++) begin : g_pitch
        vpy_cell #(
            .DATA_W (DATA_W),
            .STEP   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_pv[g]),
            .i_flags (w_pf[g]),
            .i_x     (w_px[g]),
            .i_y     (w_py[g]),
            .i_acc   (w_pa[g]),
            .i_aux   (w_paux[g]),
            .o_valid (w_pv[g+1]),
            .o_flags (w_pf[g+1]),
            .o_x     (w_px[g+1]),
            .o_y     (w_py[g+1]),
            .o_acc   (w_pa[g+1]),
            .o_aux   (w_paux[g+1])
        );
    end

    vpy_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_adv),
        .i_valid     (w_pv[STEPS]),
        .i_flags     (w_pf[STEPS]),
        .i_yaw_acc   (w_paux[STEPS][vpy_pkg::ACC_W-1:0]),
        .i_pitch_acc (w_pa[STEPS]),
        .o_valid     (o_out_valid),
        .o_pitch_deg (o_pitch_deg),
        .o_yaw_deg   (o_yaw_deg)
    );

endmodule

// ===== hw/rtl/vpy_checker.sv =====
// Port-level checker for vector_to_pitch_yaw_core, attached by bind.
// Depends on vpy_pkg and the top level's port list.
module vpy_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [14:0] o_pitch_deg,
    input logic signed [15:0] o_yaw_deg
);

    localparam logic signed [15:0] YAW_MAX   = 16'(vpy_pkg::YAW_MAX);
    localparam logic signed [14:0] PITCH_MAX = 15'(vpy_pkg::PITCH_MAX);

    // A waiting result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // A waiting result keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_pitch_deg) && $stable(o_yaw_deg))
        else $error("result changed while stalled");

    // No result directly after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown after reset");

    // The pipe takes input whenever the output register is free.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid || i_out_ready |-> o_in_ready)
        else $error("input stalled with free output");

    // Angles stay in their documented ranges.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_yaw_deg > -YAW_MAX) && (o_yaw_deg <= YAW_MAX) &&
                        (o_pitch_deg >= -PITCH_MAX) && (o_pitch_deg <= PITCH_MAX))
        else $error("angle out of range");

endmodule

bind vector_to_pitch_yaw_core vpy_checker u_vpy_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_pitch_deg (o_pitch_deg),
    .o_yaw_deg   (o_yaw_deg)
);

// ===== bench/vector_to_pitch_yaw_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for vector_to_pitch_yaw_core: directed and random vectors,
// a bit-exact CORDIC angle predictor and a scoreboard on the result channel.
// Depends on vpy_pkg and vector_to_pitch_yaw_core.
module vector_to_pitch_yaw_core_tb;

    localparam int CW          = vpy_pkg::COORD_WIDTH_DEF;
    localparam int STEPS       = (vpy_pkg::CORDIC_STEPS_DEF < vpy_pkg::TABLE_LEN) ?
                                 vpy_pkg::CORDIC_STEPS_DEF : vpy_pkg::TABLE_LEN;
    localparam int LATENCY     = 2 * STEPS + 2;
    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [14:0]   t_pitch;
    typedef logic signed [15:0]   t_yaw;

    typedef struct packed {
        t_pitch pitch;
        t_yaw   yaw;
    } t_angles;

    localparam t_coord COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(CW-1){1'b0}}};

    // Arctangent of 2^-i in degrees, 16 fractional bits, rounded to nearest.
    longint atan_q16 [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic   clk      = 1'b0;
    logic   rst_n    = 1'b0;
    logic   in_valid = 1'b0;
    logic   out_ready = 1'b0;
    t_coord vec_x    = '0;
    t_coord vec_y    = '0;
    t_coord vec_z    = '0;
    logic   in_ready;
    logic   out_valid;
    t_pitch pitch_deg;
    t_yaw   yaw_deg;

    // Test control shared with the receiver process.
    bit idle_on   = 1'b1;
    int hold_req  = 0;
    int hold_done = 0;
    int hold_count;
    int cycle_count = 0;
    int errors = 0;

    // Angles predicted for accepted vectors, oldest first.
    t_angles angles_due [$];

    vector_to_pitch_yaw_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_vec_x     (vec_x),
        .i_vec_y     (vec_y),
        .i_vec_z     (vec_z),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_pitch_deg (pitch_deg),
        .o_yaw_deg   (yaw_deg)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Vectoring CORDIC: drives vy toward zero and returns the summed angle.
    function automatic longint cordic_vectoring(inout longint vx, inout longint vy,
                                                input longint ang);
        longint sx;
        longint sy;
        int i;
        for (i = 0; i < STEPS; i++) begin
            sx = vy >>> i;
            sy = vx >>> i;
            if (vy >= 0) begin
                vx  = vx + sx;
                vy  = vy - sy;
                ang = ang + atan_q16[i];
            end else begin
                vx  = vx - sx;
                vy  = vy + sy;
                ang = ang - atan_q16[i];
            end
        end
        return ang;
    endfunction

    // Bit-exact pitch and yaw for one direction vector.
    function automatic t_angles predict_angles(input t_coord vx, input t_coord vy,
                                               input t_coord vz);
        longint x;
        longint y;
        longint z;
        longint cx;
        longint cy;
        longint t;
        longint acc;
        longint px;
        longint py;
        longint pitch;
        longint yaw;
        t_angles r;
        x = vx;
        y = vy;
        z = vz;
        pitch = 0;
        yaw = 0;
        if (x != 0 || y != 0) begin
            cx = x * (64'sd1 <<< vpy_pkg::GUARD_BITS);
            cy = y * (64'sd1 <<< vpy_pkg::GUARD_BITS);
            acc = 0;
            // Left half plane: turn a quarter first so the CORDIC converges.
            if (cx < 0) begin
                t = cx;
                if (cy >= 0) begin
                    cx = cy;
                    cy = -t;
                    acc = vpy_pkg::DEG90_Q16;
                end else begin
                    cx = -cy;
                    cy = t;
                    acc = -vpy_pkg::DEG90_Q16;
                end
            end
            acc = cordic_vectoring(cx, cy, acc);
            yaw = (acc + 256) >>> vpy_pkg::ROUND_SH;
            // Vectors on an axis give exact angles.
            if (y == 0) begin
                yaw = (x > 0) ? 0 : vpy_pkg::YAW_MAX;
            end else if (x == 0) begin
                yaw = (y > 0) ? vpy_pkg::YAW_MAX / 2 : -vpy_pkg::YAW_MAX / 2;
            end
            if (yaw > vpy_pkg::YAW_MAX || yaw <= -vpy_pkg::YAW_MAX) begin
                yaw = vpy_pkg::YAW_MAX;
            end
            // Pitch comes from the scaled horizontal length left in cx.
            if (z != 0) begin
                py = (-(z * (64'sd1 <<< vpy_pkg::GUARD_BITS)) * vpy_pkg::GAIN_Q16) >>> 16;
                px = cx;
                pitch = (cordic_vectoring(px, py, 0) + 256) >>> vpy_pkg::ROUND_SH;
                if (pitch > vpy_pkg::PITCH_MAX) begin
                    pitch = vpy_pkg::PITCH_MAX;
                end
                if (pitch < -vpy_pkg::PITCH_MAX) begin
                    pitch = -vpy_pkg::PITCH_MAX;
                end
            end
        end else if (z > 0) begin
            pitch = -vpy_pkg::PITCH_MAX;
        end else if (z < 0) begin
            pitch = vpy_pkg::PITCH_MAX;
        end
        r.pitch = t_pitch'(pitch);
        r.yaw   = t_yaw'(yaw);
        return r;
    endfunction

    // Offer one vector and wait for the transaction; valid stays high afterwards.
    task automatic send_vector(input t_coord vx, input t_coord vy, input t_coord vz);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        vec_x    <= vx;
        vec_y    <= vy;
        vec_z    <= vz;
        do @(posedge clk); while (!in_ready);
        angles_due.push_back(predict_angles(vx, vy, vz));
    endtask

    // Component values spread over zero, small, log-scaled, extreme and full range.
    function automatic t_coord rand_coord();
        t_coord v;
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = t_coord'(int'($urandom_range(0, 512)) - 256);
            2: v = t_coord'($signed($urandom) >>> $urandom_range(8, 31));
            3: begin
                case ($urandom_range(0, 3))
                    0: v = COORD_MAX;
                    1: v = COORD_MIN;
                    2: v = t_coord'(1);
                    default: v = t_coord'(-1);
                endcase
            end
            default: v = t_coord'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_random_vector();
        t_coord vx;
        t_coord vy;
        vx = rand_coord();
        vy = rand_coord();
        // Now and then sit right beside the negative x axis, where yaw wraps.
        if ($urandom_range(0, 9) == 0) begin
            vx = t_coord'(-int'($urandom_range(1 << 10, 1 << 23)));
            vy = t_coord'(int'($urandom_range(0, 6)) - 3);
        end
        send_vector(vx, vy, rand_coord());
    endtask

    // Lower valid and wait until every predicted result has been taken.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (angles_due.size() != 0) @(posedge clk);
    endtask

    // Axis cases, degenerate vectors, saturation and the extremes of each field.
    task automatic test_directed();
        send_vector(0, 0, 0);
        send_vector(0, 0, 256);
        send_vector(0, 0, -256);
        send_vector(0, 0, COORD_MIN);
        send_vector(256, 0, 0);
        send_vector(-256, 0, 0);
        send_vector(0, 256, 0);
        send_vector(0, -256, 0);
        send_vector(256, 256, 0);
        send_vector(-256, -256, 256);
        send_vector(COORD_MAX, COORD_MAX, COORD_MAX);
        send_vector(COORD_MIN, COORD_MIN, COORD_MIN);
        send_vector(COORD_MIN, 0, COORD_MAX);
        send_vector(0, COORD_MIN, COORD_MAX);
        send_vector(COORD_MAX, COORD_MIN, COORD_MIN);
        send_vector(COORD_MIN, -1, 5);
        send_vector(COORD_MIN, 1, -5);
        send_vector(1, 1, 1);
        send_vector(-1, -1, -1);
        send_vector(1, 0, COORD_MIN);
        send_vector(COORD_MIN, COORD_MAX, 0);
        send_vector(-1, 0, COORD_MAX);
        send_vector(0, 1, -1);
    endtask

    // Random vectors with idling on both channels.
    task automatic test_random_stream(input int count);
        repeat (count) send_random_vector();
    endtask

    // The receiver stalls for a long stretch while vectors keep coming,
    // so the pipe fills and the input channel stalls.
    task automatic test_input_backpressure(input int count);
        hold_req = hold_req + 1;
        repeat (count) send_random_vector();
    endtask

    // The sender stops until the pipe is empty, then resumes.
    task automatic test_pause_until_drained(input int count);
        repeat (count) send_random_vector();
        wait_drained();
        repeat (count) send_random_vector();
    endtask

    // Back-to-back vectors with no idling at all.
    task automatic test_full_rate(input int count);
        idle_on <= 1'b0;
        repeat (count) send_random_vector();
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req != hold_done) begin
                hold_done = hold_done + 1;
                out_ready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
                    @(posedge clk);
                end
                out_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Scoreboard: every result transaction against the oldest prediction.
    always @(posedge clk) begin : check_results
        t_angles due;
        if (rst_n && out_valid && out_ready) begin
            if (angles_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, got pitch %0d yaw %0d",
                         $time, pitch_deg, yaw_deg);
                errors++;
            end else begin
                due = angles_due.pop_front();
                if (pitch_deg !== due.pitch) begin
                    $display("%0t: pitch mismatch, expected %0d, got %0d",
                             $time, due.pitch, pitch_deg);
                    errors++;
                end
                if (yaw_deg !== due.yaw) begin
                    $display("%0t: yaw mismatch, expected %0d, got %0d",
                             $time, due.yaw, yaw_deg);
                    errors++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL vector_to_pitch_yaw_core");
        $finish;
    end

    // Test sequence.
    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_stream(230);
        test_input_backpressure(60);
        test_pause_until_drained(30);
        test_full_rate(100);
        wait_drained();
        repeat (LATENCY + 8) @(posedge clk);
        if (errors == 0) begin
            $display("PASS vector_to_pitch_yaw_core");
        end else begin
            $display("FAIL vector_to_pitch_yaw_core");
        end
        $finish;
    end

endmodule
